FILE: rtl/core/eclk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eclk_pkg
// Shared constants, types and the month length table of the epoch seconds
// calendar clock.
// ----------------------------------------------------------------------------
package eclk_pkg;

    localparam int TICKS_PER_SECOND = 1000;
    localparam int TPS_EFF          = (TICKS_PER_SECOND == 0) ? 1 : TICKS_PER_SECOND;

    localparam int EPOCH_W = 32;
    localparam int DIV_W   = ($clog2(TPS_EFF + 1) > 6) ? $clog2(TPS_EFF + 1) : 6;
    localparam int DAYS_W  = 16;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int WDAY_W  = 3;
    localparam int DOY_W   = 9;

    localparam logic [EPOCH_W-1:0] UNSET_MARK = '1;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
    localparam logic [1:0]        Y4_INIT    = 2'd2;
    localparam logic [6:0]        Y100_INIT  = 7'd70;
    localparam logic [8:0]        Y400_INIT  = 9'd370;

    localparam logic [DIV_W-1:0] DIVISOR_TPS  = DIV_W'(TPS_EFF);
    localparam logic [DIV_W-1:0] DIVISOR_60   = DIV_W'(60);
    localparam logic [DIV_W-1:0] DIVISOR_24   = DIV_W'(24);
    localparam logic [DIV_W-1:0] DIVISOR_7    = DIV_W'(7);
    localparam logic [EPOCH_W-1:0] WDAY_BIAS  = EPOCH_W'(4);

    // reciprocal division: q = (n * ceil(2^s / d)) >> s, s = 32 + ceil(log2 d)
    localparam int          RECIP_W = EPOCH_W + 1;
    localparam int          PROD_W  = EPOCH_W + RECIP_W;
    localparam int          SHIFT_W = $clog2(2 * EPOCH_W);
    localparam logic [63:0] POW_ONE = 64'd1;

    localparam logic [SHIFT_W-1:0] SHIFT_TPS = SHIFT_W'(EPOCH_W + $clog2(TPS_EFF));
    localparam logic [SHIFT_W-1:0] SHIFT_60  = SHIFT_W'(EPOCH_W + $clog2(60));
    localparam logic [SHIFT_W-1:0] SHIFT_24  = SHIFT_W'(EPOCH_W + $clog2(24));
    localparam logic [SHIFT_W-1:0] SHIFT_7   = SHIFT_W'(EPOCH_W + $clog2(7));

    localparam logic [RECIP_W-1:0] RECIP_TPS =
        RECIP_W'(((POW_ONE << SHIFT_TPS) + 64'(TPS_EFF - 1)) / 64'(TPS_EFF));
    localparam logic [RECIP_W-1:0] RECIP_60 =
        RECIP_W'(((POW_ONE << SHIFT_60) + 64'(59)) / 64'(60));
    localparam logic [RECIP_W-1:0] RECIP_24 =
        RECIP_W'(((POW_ONE << SHIFT_24) + 64'(23)) / 64'(24));
    localparam logic [RECIP_W-1:0] RECIP_7 =
        RECIP_W'(((POW_ONE << SHIFT_7) + 64'(6)) / 64'(7));

    typedef enum logic [2:0] {
        DIV_TICK,
        DIV_SEC,
        DIV_MIN,
        DIV_HOUR,
        DIV_WDAY
    } t_div_op;

    typedef struct packed {
        logic    take_in;
        logic    epoch_load;
        logic    epoch_inc;
        logic    div_start;
        t_div_op div_op;
        logic    cap_sec;
        logic    cap_min;
        logic    cap_hour;
        logic    cap_wday;
        logic    year_step;
        logic    month_init;
        logic    month_step;
        logic    commit_cal;
        logic    out_load;
        logic    adv;
    } t_dp_cmd;

    typedef struct packed {
        logic mode;
        logic div_done;
        logic rem_zero;
        logic epoch_unset;
        logic year_fits;
        logic month_stop;
        logic out_free;
    } t_dp_status;

    // month index is zero based
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:                   len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/eclk_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eclk_divider
// Division of a 32-bit value by one of the fixed divisors through reciprocal
// multiplication. Operand capture, product, quotient and remainder are
// registered in that order; o_done pulses for one cycle with the remainder.
// ----------------------------------------------------------------------------
module eclk_divider import eclk_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire t_div_op            i_op,
    input  wire logic [EPOCH_W-1:0] i_dividend,
    output logic                    o_done,
    output logic [EPOCH_W-1:0]      o_quotient,
    output logic [DIV_W-1:0]        o_remainder
);

    logic                     r_mul_go;
    logic                     r_quo_go;
    logic                     r_rem_go;
    logic                     r_done;
    logic [EPOCH_W-1:0]       r_num;
    logic [RECIP_W-1:0]       r_recip;
    logic [SHIFT_W-1:0]       r_shift;
    logic [DIV_W-1:0]         r_div;
    logic [PROD_W-1:0]        r_prod;
    logic [EPOCH_W-1:0]       r_quo;
    logic [DIV_W-1:0]         r_rem;

    logic [RECIP_W-1:0]       w_recip;
    logic [SHIFT_W-1:0]       w_shift;
    logic [DIV_W-1:0]         w_div;
    logic [PROD_W-1:0]        w_quo_full;
    logic [EPOCH_W+DIV_W-1:0] w_back;

    always_comb begin
        case (i_op)
            DIV_SEC, DIV_MIN: begin
                w_div   = DIVISOR_60;
                w_recip = RECIP_60;
                w_shift = SHIFT_60;
            end
            DIV_HOUR: begin
                w_div   = DIVISOR_24;
                w_recip = RECIP_24;
                w_shift = SHIFT_24;
            end
            DIV_WDAY: begin
                w_div   = DIVISOR_7;
                w_recip = RECIP_7;
                w_shift = SHIFT_7;
            end
            default: begin
                w_div   = DIVISOR_TPS;
                w_recip = RECIP_TPS;
                w_shift = SHIFT_TPS;
            end
        endcase
    end

    assign w_quo_full = r_prod >> r_shift;
    assign w_back     = r_quo * r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_go <= 1'b0;
            r_quo_go <= 1'b0;
            r_rem_go <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_mul_go <= i_start;
            r_quo_go <= r_mul_go;
            r_rem_go <= r_quo_go;
            r_done   <= r_rem_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num   <= i_dividend;
            r_recip <= w_recip;
            r_shift <= w_shift;
            r_div   <= w_div;
        end
        if (r_mul_go) begin
            r_prod <= r_num * r_recip;
        end
        if (r_quo_go) begin
            r_quo <= w_quo_full[EPOCH_W-1:0];
        end
        if (r_rem_go) begin
            r_rem <= DIV_W'(r_num - w_back[EPOCH_W-1:0]);
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

FILE: rtl/core/eclk_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eclk_datapath
// Seconds count, calendar decode registers, year and month walk, shared
// divider and the output register.
// ----------------------------------------------------------------------------
module eclk_datapath import eclk_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_mode,
    input  wire logic [EPOCH_W-1:0] i_tick_count,
    input  wire logic [EPOCH_W-1:0] i_load_seconds,
    input  wire logic               i_out_stall,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_status              o_status,
    output logic                    o_out_valid,
    output logic                    o_clock_set,
    output logic                    o_advanced,
    output logic [EPOCH_W-1:0]      o_seconds_now,
    output logic [YEAR_W-1:0]       o_cal_year,
    output logic [MONTH_W-1:0]      o_cal_month,
    output logic [DAY_W-1:0]        o_cal_day,
    output logic [HOUR_W-1:0]       o_cal_hour,
    output logic [MIN_W-1:0]        o_cal_minute,
    output logic [SEC_W-1:0]        o_cal_second,
    output logic [WDAY_W-1:0]       o_cal_weekday,
    output logic [DOY_W-1:0]        o_cal_day_of_year
);

    // latched transaction
    logic               r_mode;
    logic [EPOCH_W-1:0] r_tick;
    logic [EPOCH_W-1:0] r_load;

    logic [EPOCH_W-1:0] r_epoch;

    // walk state
    logic [DAYS_W-1:0]  r_rem_days;
    logic [YEAR_W-1:0]  r_year;
    logic [1:0]         r_y4;
    logic [6:0]         r_y100;
    logic [8:0]         r_y400;
    logic [MONTH_W-1:0] r_mon;
    logic               r_leap;

    // held calendar
    logic [YEAR_W-1:0]  r_year_h;
    logic [MONTH_W-1:0] r_month_h;
    logic [DAY_W-1:0]   r_day_h;
    logic [HOUR_W-1:0]  r_hour_h;
    logic [MIN_W-1:0]   r_min_h;
    logic [SEC_W-1:0]   r_sec_h;
    logic [WDAY_W-1:0]  r_wday_h;
    logic [DOY_W-1:0]   r_doy_h;

    // output register
    logic               r_out_valid;
    logic               r_out_set;
    logic               r_out_adv;
    logic [EPOCH_W-1:0] r_out_secs;
    logic [YEAR_W-1:0]  r_out_year;
    logic [MONTH_W-1:0] r_out_month;
    logic [DAY_W-1:0]   r_out_day;
    logic [HOUR_W-1:0]  r_out_hour;
    logic [MIN_W-1:0]   r_out_min;
    logic [SEC_W-1:0]   r_out_sec;
    logic [WDAY_W-1:0]  r_out_wday;
    logic [DOY_W-1:0]   r_out_doy;

    logic [EPOCH_W-1:0] w_dividend;
    logic               w_div_done;
    logic [EPOCH_W-1:0] w_quo;
    logic [DIV_W-1:0]   w_rem;

    logic               w_leap;
    logic [8:0]         w_ylen;
    logic [DAY_W-1:0]   w_mlen;

    always_comb begin
        case (i_cmd.div_op)
            DIV_TICK: begin
                w_dividend = r_tick;
            end
            DIV_SEC: begin
                w_dividend = r_epoch;
            end
            DIV_MIN: begin
                w_dividend = w_quo;
            end
            DIV_HOUR: begin
                w_dividend = w_quo;
            end
            DIV_WDAY: begin
                w_dividend = w_quo + WDAY_BIAS;
            end
            default: begin
                w_dividend = r_tick;
            end
        endcase
    end

    eclk_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_op        (i_cmd.div_op),
        .i_dividend  (w_dividend),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    assign w_leap = ((r_y4 == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);
    assign w_ylen = w_leap ? 9'd366 : 9'd365;
    assign w_mlen = month_len(r_leap, r_mon);

    always_comb begin
        o_status.mode        = r_mode;
        o_status.div_done    = w_div_done;
        o_status.rem_zero    = (w_rem == '0);
        o_status.epoch_unset = (r_epoch == UNSET_MARK);
        o_status.year_fits   = (r_rem_days < DAYS_W'(w_ylen));
        o_status.month_stop  = (r_mon == 4'd11) || (r_rem_days < DAYS_W'(w_mlen));
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_mode <= i_mode;
            r_tick <= i_tick_count;
            r_load <= i_load_seconds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch   <= UNSET_MARK;
            r_year_h  <= '0;
            r_month_h <= '0;
            r_day_h   <= '0;
            r_hour_h  <= '0;
            r_min_h   <= '0;
            r_sec_h   <= '0;
            r_wday_h  <= '0;
            r_doy_h   <= '0;
        end else begin
            if (i_cmd.epoch_load) begin
                r_epoch <= r_load;
            end else if (i_cmd.epoch_inc) begin
                r_epoch <= r_epoch + EPOCH_W'(1);
            end
            if (i_cmd.cap_sec) begin
                r_sec_h <= w_rem[SEC_W-1:0];
            end
            if (i_cmd.cap_min) begin
                r_min_h <= w_rem[MIN_W-1:0];
            end
            if (i_cmd.cap_hour) begin
                r_hour_h <= w_rem[HOUR_W-1:0];
            end
            if (i_cmd.cap_wday) begin
                r_wday_h <= w_rem[WDAY_W-1:0];
            end
            if (i_cmd.month_init) begin
                r_year_h <= r_year;
                r_doy_h  <= r_rem_days[DOY_W-1:0];
            end
            if (i_cmd.commit_cal) begin
                r_month_h <= r_mon + MONTH_W'(1);
                r_day_h   <= r_rem_days[DAY_W-1:0] + DAY_W'(1);
            end
        end
    end

    // year and month walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_hour) begin
            r_rem_days <= w_quo[DAYS_W-1:0];
            r_year     <= EPOCH_YEAR;
            r_y4       <= Y4_INIT;
            r_y100     <= Y100_INIT;
            r_y400     <= Y400_INIT;
        end else if (i_cmd.year_step) begin
            r_rem_days <= r_rem_days - DAYS_W'(w_ylen);
            r_year     <= r_year + YEAR_W'(1);
            r_y4       <= r_y4 + 2'd1;
            r_y100     <= (r_y100 == 7'd99) ? 7'd0 : r_y100 + 7'd1;
            r_y400     <= (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
        end else if (i_cmd.month_step) begin
            r_rem_days <= r_rem_days - DAYS_W'(w_mlen);
        end
        if (i_cmd.month_init) begin
            r_mon  <= '0;
            r_leap <= w_leap;
        end else if (i_cmd.month_step) begin
            r_mon <= r_mon + MONTH_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_set   <= (r_epoch != UNSET_MARK);
            r_out_adv   <= i_cmd.adv;
            r_out_secs  <= r_epoch;
            r_out_year  <= r_year_h;
            r_out_month <= r_month_h;
            r_out_day   <= r_day_h;
            r_out_hour  <= r_hour_h;
            r_out_min   <= r_min_h;
            r_out_sec   <= r_sec_h;
            r_out_wday  <= r_wday_h;
            r_out_doy   <= r_doy_h;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_clock_set       = r_out_set;
    assign o_advanced        = r_out_adv;
    assign o_seconds_now     = r_out_secs;
    assign o_cal_year        = r_out_year;
    assign o_cal_month       = r_out_month;
    assign o_cal_day         = r_out_day;
    assign o_cal_hour        = r_out_hour;
    assign o_cal_minute      = r_out_min;
    assign o_cal_second      = r_out_sec;
    assign o_cal_weekday     = r_out_wday;
    assign o_cal_day_of_year = r_out_doy;

endmodule
`default_nettype wire

FILE: rtl/core/eclk_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eclk_ctrl
// Sequencer for one transaction: seconds load, or tick boundary check,
// increment, division chain for time of day and weekday, year and month walk;
// result hand-off in both cases.
module eclk_ctrl import eclk_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_TPS,
        S_SEC_GO,
        S_SEC,
        S_MIN,
        S_HOUR,
        S_WDAY,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_adv;
    logic   n_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_adv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_adv   <= n_adv;
        end
    end

    always_comb begin
        n_state = r_state;
        n_adv   = r_adv;
        o_cmd   = '0;
        o_cmd.div_op = DIV_TICK;
        o_cmd.adv    = r_adv;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = S_START;
                end
            end
            S_START: begin
                if (i_status.mode) begin
                    o_cmd.epoch_load = 1'b1;
                    n_adv            = 1'b0;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DIV_TICK;
                    n_state         = S_TPS;
                end
            end
            S_TPS: begin
                if (i_status.div_done) begin
                    if (i_status.rem_zero && !i_status.epoch_unset) begin
                        o_cmd.epoch_inc = 1'b1;
                        n_state         = S_SEC_GO;
                    end else begin
                        n_adv   = 1'b0;
                        n_state = S_DONE;
                    end
                end
            end
            S_SEC_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_SEC;
                n_state         = S_SEC;
            end
            S_SEC: begin
                if (i_status.div_done) begin
                    o_cmd.cap_sec   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DIV_MIN;
                    n_state         = S_MIN;
                end
            end
            S_MIN: begin
                if (i_status.div_done) begin
                    o_cmd.cap_min   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DIV_HOUR;
                    n_state         = S_HOUR;
                end
            end
            S_HOUR: begin
                if (i_status.div_done) begin
                    o_cmd.cap_hour  = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DIV_WDAY;
                    n_state         = S_WDAY;
                end
            end
            S_WDAY: begin
                o_cmd.div_op = DIV_WDAY;
                if (i_status.div_done) begin
                    o_cmd.cap_wday = 1'b1;
                    n_state        = S_YEAR;
                end
            end
            S_YEAR: begin
                if (i_status.year_fits) begin
                    o_cmd.month_init = 1'b1;
                    n_state          = S_MONTH;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            S_MONTH: begin
                if (i_status.month_stop) begin
                    o_cmd.commit_cal = 1'b1;
                    n_adv            = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

FILE: rtl/core/epoch_seconds_calendar_clock.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_calendar_clock
// Seconds-since-1970 real-time clock with UTC calendar decode.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time; o_in_stall is high from acceptance
// until the result has moved into the output register, and the next
// transaction can be taken while that result still waits downstream. A load
// passes the start and done states; the done state waits until the output
// register is free. A tick passes one reciprocal division that tests the tick
// counter for a second boundary. A tick that advances the clock adds a start
// state, four more divisions (seconds, minutes, hours, weekday), one year walk
// step per year since 1970 and one month walk step per month before the
// current one. The all-ones count means the clock is unset and it then
// ignores ticks until loaded.
// ----------------------------------------------------------------------------
module epoch_seconds_calendar_clock import eclk_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_mode,
    input  wire logic [EPOCH_W-1:0] i_tick_count,
    input  wire logic [EPOCH_W-1:0] i_load_seconds,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_clock_set,
    output logic                    o_advanced,
    output logic [EPOCH_W-1:0]      o_seconds_now,
    output logic [YEAR_W-1:0]       o_cal_year,
    output logic [MONTH_W-1:0]      o_cal_month,
    output logic [DAY_W-1:0]        o_cal_day,
    output logic [HOUR_W-1:0]       o_cal_hour,
    output logic [MIN_W-1:0]        o_cal_minute,
    output logic [SEC_W-1:0]        o_cal_second,
    output logic [WDAY_W-1:0]       o_cal_weekday,
    output logic [DOY_W-1:0]        o_cal_day_of_year
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    eclk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    eclk_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_mode            (i_mode),
        .i_tick_count      (i_tick_count),
        .i_load_seconds    (i_load_seconds),
        .i_out_stall       (i_out_stall),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_out_valid       (o_out_valid),
        .o_clock_set       (o_clock_set),
        .o_advanced        (o_advanced),
        .o_seconds_now     (o_seconds_now),
        .o_cal_year        (o_cal_year),
        .o_cal_month       (o_cal_month),
        .o_cal_day         (o_cal_day),
        .o_cal_hour        (o_cal_hour),
        .o_cal_minute      (o_cal_minute),
        .o_cal_second      (o_cal_second),
        .o_cal_weekday     (o_cal_weekday),
        .o_cal_day_of_year (o_cal_day_of_year)
    );

endmodule
`default_nettype wire

FILE: rtl/core/eclk_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eclk_checker
// Port-level checks for the epoch seconds calendar clock, bound to the top.
// ----------------------------------------------------------------------------
module eclk_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        i_mode,
    input wire logic [31:0] i_tick_count,
    input wire logic [31:0] i_load_seconds,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_clock_set,
    input wire logic        o_advanced,
    input wire logic [31:0] o_seconds_now,
    input wire logic [11:0] o_cal_year,
    input wire logic [3:0]  o_cal_month,
    input wire logic [4:0]  o_cal_day,
    input wire logic [4:0]  o_cal_hour,
    input wire logic [5:0]  o_cal_minute,
    input wire logic [5:0]  o_cal_second,
    input wire logic [2:0]  o_cal_weekday,
    input wire logic [8:0]  o_cal_day_of_year
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_seconds_now) && $stable(o_advanced))
        else $error("stalled result changed");

    // one transaction in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken while busy");

    a_set_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_clock_set == (o_seconds_now != 32'hFFFF_FFFF)))
        else $error("clock_set disagrees with seconds count");

    a_cal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_advanced |->
            o_cal_month >= 4'd1 && o_cal_month <= 4'd12 && o_cal_day >= 5'd1
            && o_cal_hour < 5'd24 && o_cal_minute < 6'd60 && o_cal_second < 6'd60
            && o_cal_weekday < 3'd7 && o_cal_day_of_year < 9'd366
            && o_cal_year >= 12'd1970)
        else $error("decoded calendar out of range");

endmodule

bind epoch_seconds_calendar_clock eclk_checker u_eclk_checker (.*);
`default_nettype wire
